/* hw/rtl/ctm_pkg.sv */
// ctm_pkg: shared types and constants for the cassette tone modulator
// no dependencies; imported by every module of the block

package ctm_pkg;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int LEADER_W = 16;
    localparam int FBITS_W  = 4;
    localparam int TICKS_W  = 5;
    localparam int OUT_DATA_W = 8;

    // parameter defaults
    localparam int TICKS_PER_BIT_DEF = 16;
    localparam int FRAME_BITS_DEF    = 10;

    // register reset values
    localparam logic [LEADER_W-1:0] LEADER_RESET = 16'd15000;

    // event kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_SEND        = 2'd1,
        FUNC_CARRIER_ON  = 2'd2,
        FUNC_CARRIER_OFF = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPE_ENABLE   = 1'b0,
        CFG_LEADER_LENGTH = 1'b1
    } t_cfg_idx;

    // one result item
    typedef struct packed {
        logic byte_request;
        logic tone_phase;
        logic tape_level;
    } t_result;

endpackage

/* hw/rtl/ctm_core.sv */
// ctm_core: modulator state, configuration registers and per-event update
// depends on ctm_pkg

module ctm_core
    import ctm_pkg::*;
#(
    parameter int TICKS_PER_BIT = TICKS_PER_BIT_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [BYTE_W-1:0]    i_byte,
    output t_result              o_result
);

    localparam logic [TICKS_W-1:0] TPB    = TICKS_W'(TICKS_PER_BIT);
    localparam logic [FBITS_W-1:0] FBITS  = FBITS_W'(FRAME_BITS);
    localparam int                 STOP_W = FRAME_BITS - BYTE_W - 1;

    logic                  r_tape_enable;
    logic [LEADER_W-1:0]   r_leader_length;
    logic                  r_tone_bit, n_tone_bit;
    logic                  r_level, n_level;
    logic [LEADER_W-1:0]   r_leader_count, n_leader_count;
    logic [FBITS_W-1:0]    r_frame_bits_left, n_frame_bits_left;
    logic [TICKS_W-1:0]    r_ticks_left, n_ticks_left;
    logic [FRAME_BITS-1:0] r_frame_shift, n_frame_shift;
    logic                  req;
    logic [LEADER_W-1:0]   leader_dec;
    logic [TICKS_W-1:0]    ticks_dec;
    logic [FBITS_W-1:0]    fbits_dec;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_enable   <= 1'b0;
            r_leader_length <= LEADER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TAPE_ENABLE:   r_tape_enable   <= i_cfg_data[0];
                CFG_LEADER_LENGTH: r_leader_length <= i_cfg_data[LEADER_W-1:0];
                default:           r_tape_enable   <= r_tape_enable;
            endcase
        end
    end

    assign leader_dec = r_leader_count - LEADER_W'(1);
    assign ticks_dec  = r_ticks_left - TICKS_W'(1);
    assign fbits_dec  = r_frame_bits_left - FBITS_W'(1);

    // next state for one event
    always_comb begin
        n_tone_bit        = r_tone_bit;
        n_level           = r_level;
        n_leader_count    = r_leader_count;
        n_frame_bits_left = r_frame_bits_left;
        n_ticks_left      = r_ticks_left;
        n_frame_shift     = r_frame_shift;
        req               = 1'b0;
        unique case (t_func'(i_func))
            FUNC_TICK: begin
                n_tone_bit = ~r_tone_bit;
                if (!r_tape_enable) begin
                    req = 1'b0;
                end else if (r_leader_count != '0) begin
                    // leader tone toggles every tick
                    n_leader_count = leader_dec;
                    n_level        = leader_dec[0];
                    req            = (leader_dec == '0);
                end else if (r_frame_bits_left != '0) begin
                    // one toggles every tick, zero every two ticks
                    n_level      = r_frame_shift[0] ? r_ticks_left[0] : r_ticks_left[1];
                    n_ticks_left = ticks_dec;
                    if (ticks_dec == '0) begin
                        n_frame_bits_left = fbits_dec;
                        n_frame_shift     = r_frame_shift >> 1;
                        if (fbits_dec == '0) begin
                            req = 1'b1;
                        end else begin
                            n_ticks_left = TPB;
                        end
                    end
                end else begin
                    // idle asks for more
                    req = 1'b1;
                end
            end
            FUNC_SEND: begin
                // start bit low, data lsb first, stop bits high
                n_frame_shift     = {{STOP_W{1'b1}}, i_byte, 1'b0};
                n_frame_bits_left = FBITS;
                n_ticks_left      = TPB;
            end
            FUNC_CARRIER_ON: begin
                n_leader_count = r_leader_length;
            end
            FUNC_CARRIER_OFF: begin
                n_leader_count = '0;
            end
            default: begin
                n_leader_count = r_leader_count;
            end
        endcase
    end

    // state update on accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_bit        <= 1'b0;
            r_level           <= 1'b0;
            r_leader_count    <= '0;
            r_frame_bits_left <= '0;
            r_ticks_left      <= '0;
            r_frame_shift     <= '0;
        end else if (i_accept) begin
            r_tone_bit        <= n_tone_bit;
            r_level           <= n_level;
            r_leader_count    <= n_leader_count;
            r_frame_bits_left <= n_frame_bits_left;
            r_ticks_left      <= n_ticks_left;
            r_frame_shift     <= n_frame_shift;
        end
    end

    // result reflects the updated state
    assign o_result.tape_level   = n_level;
    assign o_result.tone_phase   = n_tone_bit;
    assign o_result.byte_request = req;

endmodule

/* hw/rtl/ctm_out_reg.sv */
// ctm_out_reg: registered output stage of the result stream
// depends on ctm_pkg

module ctm_out_reg
    import ctm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // take a new result when empty or when the held one leaves
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/cassette_tone_modulator.sv */
// cassette_tone_modulator: top level of the cassette output modulator
// depends on ctm_pkg, ctm_core and ctm_out_reg

// Cassette output modulator in the Kansas City style. Each request on the
// slave stream is one event (tick, send byte, carrier on, carrier off) and
// yields exactly one result on the master stream: the tape level, the tone
// phase and a byte request flag. Events are taken one per clock; the
// modulator state updates in the cycle of acceptance and the result sits in
// one output register, so a new event is accepted whenever that register is
// empty or is being drained in the same cycle. Configuration (tape enable,
// leader length) is written through the plain write port; the user must do
// so only while the block is idle, which the block itself does not enforce.

module cassette_tone_modulator
    import ctm_pkg::*;
#(
    parameter int TICKS_PER_BIT = TICKS_PER_BIT_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // event stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] byte_in
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // [1:0] func
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] tape_level, [1] tone_phase,
                                                  // [2] byte_request, [7:3] zero
);

    logic    accept;
    t_result core_result;
    t_result out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    // modulator state and event update
    ctm_core #(
        .TICKS_PER_BIT (TICKS_PER_BIT),
        .FRAME_BITS    (FRAME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_result    (core_result)
    );

    // result register
    ctm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {5'b0, out_result.byte_request, out_result.tone_phase,
                           out_result.tape_level};

endmodule
